// ===== hdl/dmwbc_pkg.sv =====
// Shared widths and command codes for the direct-mapped write-back cache.
// No dependencies.
package dmwbc_pkg;

    localparam int ADDR_W = 16;
    localparam int DATA_W = 32;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic wrote_back;
        logic hit;
    } result_flags_t;

endpackage

// ===== hdl/dmwbc_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module dmwbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/direct_mapped_writeback_cache.sv =====
// Top level of the direct-mapped write-back, write-allocate cache.
// Depends on dmwbc_pkg and dmwbc_ram (backing memory, line words, line tags).
//
// After reset the block sweeps the backing memory to zero, one word a cycle, and
// takes no item until the sweep is done. A hit request then passes through
// accept, tag and word lookup, and result. A clean miss adds a line fill, and a
// dirty miss adds a write-back of the victim line before the fill; both copies
// move one word a cycle through the single registered read port of each memory.
// One request is in flight at a time; a finished result sits in the output
// register while the next item is taken. The user must keep LINES,
// WORDS_PER_LINE and MEM_WORDS powers of two; the block does not enforce it.
module direct_mapped_writeback_cache #(
    parameter int LINES          = 32,
    parameter int WORDS_PER_LINE = 8,
    parameter int MEM_WORDS      = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // address [15:0], write_data [47:16]
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data
    output logic [1:0]  m_tuser    // hit [0], wrote_back [1]
);

    localparam int ADDR_W = dmwbc_pkg::ADDR_W;
    localparam int DATA_W = dmwbc_pkg::DATA_W;
    localparam int OFF_W  = $clog2(WORDS_PER_LINE);
    localparam int IDX_W  = $clog2(LINES);
    localparam int LW_AW  = OFF_W + IDX_W;
    localparam int TAG_W  = (ADDR_W > LW_AW) ? ADDR_W - LW_AW : 1;
    localparam int MEM_AW = $clog2(MEM_WORDS);
    localparam int STEP_W = OFF_W + 1;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LOOKUP = 3'd2;
    localparam logic [2:0] ST_WB     = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [MEM_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [LINES-1:0]   valid_reg, valid_next;
    logic [LINES-1:0]   dirty_reg, dirty_next;

    logic               req_cmd_reg, req_cmd_next;
    logic [ADDR_W-1:0]  req_addr_reg, req_addr_next;
    logic [DATA_W-1:0]  req_wdata_reg, req_wdata_next;
    logic [TAG_W-1:0]   vtag_reg, vtag_next;
    logic [DATA_W-1:0]  rdata_reg, rdata_next;
    dmwbc_pkg::result_flags_t flags_reg, flags_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    dmwbc_pkg::result_flags_t m_flags_reg, m_flags_next;

    logic [OFF_W-1:0]   req_off;
    logic [IDX_W-1:0]   req_idx;
    logic [TAG_W-1:0]   req_tag;
    logic [OFF_W-1:0]   step_cur;
    logic [OFF_W-1:0]   step_prev;
    logic [IDX_W-1:0]   s_idx;
    logic               lookup_hit;
    logic               out_free;
    logic [ADDR_W-1:0]  victim_addr;
    logic [ADDR_W-1:0]  fill_addr;

    logic               line_we;
    logic [LW_AW-1:0]   line_waddr, line_raddr;
    logic [DATA_W-1:0]  line_wdata, line_rdata;
    logic               tag_we;
    logic [TAG_W-1:0]   tag_rdata;
    logic               mem_we;
    logic [MEM_AW-1:0]  mem_waddr, mem_raddr;
    logic [DATA_W-1:0]  mem_wdata, mem_rdata;

    assign req_off   = req_addr_reg[OFF_W-1:0];
    assign req_idx   = req_addr_reg[LW_AW-1:OFF_W];
    assign req_tag   = TAG_W'(req_addr_reg >> LW_AW);
    assign step_cur  = step_reg[OFF_W-1:0];
    assign step_prev = OFF_W'(step_reg - STEP_W'(1));
    assign s_idx     = s_tdata[LW_AW-1:OFF_W];

    assign lookup_hit  = valid_reg[req_idx] && (tag_rdata == req_tag);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign victim_addr = (ADDR_W'(vtag_reg) << LW_AW) | ADDR_W'({req_idx, step_prev});
    assign fill_addr   = {req_addr_reg[ADDR_W-1:OFF_W], step_cur};

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_flags_reg;

    // memory ports
    always_comb begin
        line_raddr = (state_reg == ST_WB) ? {req_idx, step_cur} : s_tdata[LW_AW-1:0];
        line_we    = 1'b0;
        line_waddr = {req_idx, req_off};
        line_wdata = req_wdata_reg;
        if (state_reg == ST_LOOKUP && lookup_hit && req_cmd_reg == dmwbc_pkg::CMD_WRITE) begin
            line_we = 1'b1;
        end
        if (state_reg == ST_FILL && step_reg != '0) begin
            line_we    = 1'b1;
            line_waddr = {req_idx, step_prev};
            if (!(req_cmd_reg == dmwbc_pkg::CMD_WRITE && step_prev == req_off)) begin
                line_wdata = mem_rdata;
            end
        end

        tag_we    = (state_reg == ST_LOOKUP) && !lookup_hit;
        mem_raddr = MEM_AW'(fill_addr);
        mem_we    = 1'b0;
        mem_waddr = MEM_AW'(victim_addr);
        mem_wdata = line_rdata;
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else if (state_reg == ST_WB && step_reg != '0) begin
            mem_we = 1'b1;
        end
    end

    // request sequencer
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        step_next      = step_reg;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        req_cmd_next   = req_cmd_reg;
        req_addr_next  = req_addr_reg;
        req_wdata_next = req_wdata_reg;
        vtag_next      = vtag_reg;
        rdata_next     = rdata_reg;
        flags_next     = flags_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_flags_next   = m_flags_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + MEM_AW'(1);
                if (clr_cnt_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_cmd_next   = s_tuser;
                    req_addr_next  = s_tdata[ADDR_W-1:0];
                    req_wdata_next = s_tdata[47:16];
                    state_next     = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                vtag_next       = tag_rdata;
                flags_next.hit  = lookup_hit;
                step_next       = '0;
                rdata_next      = '0;
                if (lookup_hit) begin
                    flags_next.wrote_back = 1'b0;
                    if (req_cmd_reg == dmwbc_pkg::CMD_WRITE) begin
                        dirty_next[req_idx] = 1'b1;
                    end else begin
                        rdata_next = line_rdata;
                    end
                    state_next = ST_DONE;
                end else begin
                    flags_next.wrote_back = valid_reg[req_idx] && dirty_reg[req_idx];
                    valid_next[req_idx]   = 1'b1;
                    dirty_next[req_idx]   = (req_cmd_reg == dmwbc_pkg::CMD_WRITE);
                    state_next = (valid_reg[req_idx] && dirty_reg[req_idx]) ? ST_WB : ST_FILL;
                end
            end
            ST_WB: begin
                if (step_reg == STEP_W'(WORDS_PER_LINE)) begin
                    step_next  = '0;
                    state_next = ST_FILL;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_FILL: begin
                if (step_reg != '0 && step_prev == req_off
                    && req_cmd_reg == dmwbc_pkg::CMD_READ) begin
                    rdata_next = mem_rdata;
                end
                if (step_reg == STEP_W'(WORDS_PER_LINE)) begin
                    state_next = ST_DONE;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = rdata_reg;
                    m_flags_next  = flags_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            step_reg     <= '0;
            valid_reg    <= '0;
            dirty_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            step_reg     <= step_next;
            valid_reg    <= valid_next;
            dirty_reg    <= dirty_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_cmd_reg   <= req_cmd_next;
        req_addr_reg  <= req_addr_next;
        req_wdata_reg <= req_wdata_next;
        vtag_reg      <= vtag_next;
        rdata_reg     <= rdata_next;
        flags_reg     <= flags_next;
        m_tdata_reg   <= m_tdata_next;
        m_flags_reg   <= m_flags_next;
    end

    dmwbc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LINES * WORDS_PER_LINE)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    dmwbc_ram #(
        .WIDTH (TAG_W),
        .DEPTH (LINES)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (req_idx),
        .wdata (req_tag),
        .raddr (s_idx),
        .rdata (tag_rdata)
    );

    dmwbc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_backing_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    a_hit_no_writeback: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_flags_reg.hit && m_flags_reg.wrote_back))
        else $error("result reports a write-back on a hit");

    a_miss_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOKUP && !lookup_hit) |=> valid_reg[req_idx])
        else $error("line not valid after a miss");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= STEP_W'(WORDS_PER_LINE))
        else $error("line copy counter out of range");

    a_no_mem_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_WB))
        else $error("backing memory written outside clear or write-back");

endmodule

// ===== tb/direct_mapped_writeback_cache_test.sv =====
// Self-checking testbench for direct_mapped_writeback_cache: directed and random
// read/write traffic with idling and back-pressure, checked against a local cache predictor.
// Depends on dmwbc_pkg and the direct_mapped_writeback_cache RTL.
`timescale 1ns / 1ps

module direct_mapped_writeback_cache_test;

    localparam int ADDR_W         = dmwbc_pkg::ADDR_W;
    localparam int DATA_W         = dmwbc_pkg::DATA_W;
    localparam int CACHE_LINES    = 32;
    localparam int LINE_WORDS     = 8;
    localparam int MEM_DEPTH      = 65536;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int LONG_HOLD      = 200;

    typedef struct {
        logic [DATA_W-1:0] read_data;
        logic              hit;
        logic              wrote_back;
    } access_result_t;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata  = '0;   // address [15:0], write_data [47:16]
    logic              s_tuser  = dmwbc_pkg::CMD_READ;   // command
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;         // read_data
    logic [1:0]        m_tuser;         // hit [0], wrote_back [1]

    logic [DATA_W-1:0] mem_image   [0:MEM_DEPTH-1];
    logic [DATA_W-1:0] line_image  [0:CACHE_LINES*LINE_WORDS-1];
    logic [7:0]        tag_image   [0:CACHE_LINES-1];
    logic              valid_image [0:CACHE_LINES-1];
    logic              dirty_image [0:CACHE_LINES-1];

    access_result_t    pending_results [$];

    int  error_count     = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  hits_seen       = 0;
    int  writebacks_seen = 0;
    bit  tx_idle         = 1'b1;
    bit  rx_idle         = 1'b1;
    int  hold_request    = 0;

    direct_mapped_writeback_cache dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge aclk);
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("direct_mapped_writeback_cache test failed");
        $finish;
    end

    function automatic access_result_t predict_access(input logic cmd,
                                                      input logic [ADDR_W-1:0] addr,
                                                      input logic [DATA_W-1:0] wdata);
        access_result_t    r;
        logic [4:0]        idx;
        logic [2:0]        offs;
        logic [7:0]        tg;
        logic [ADDR_W-1:0] base;
        int                w;
        idx  = addr[7:3];
        offs = addr[2:0];
        tg   = addr[15:8];
        r.read_data  = '0;
        r.wrote_back = 1'b0;
        r.hit        = valid_image[idx] && tag_image[idx] == tg;
        if (!r.hit) begin
            if (valid_image[idx] && dirty_image[idx]) begin
                base = {tag_image[idx], idx, 3'b000};
                for (w = 0; w < LINE_WORDS; w++)
                    mem_image[base + ADDR_W'(w)] = line_image[{idx, w[2:0]}];
                r.wrote_back = 1'b1;
            end
            base = {addr[15:3], 3'b000};
            for (w = 0; w < LINE_WORDS; w++)
                line_image[{idx, w[2:0]}] = mem_image[base + ADDR_W'(w)];
            tag_image[idx]   = tg;
            valid_image[idx] = 1'b1;
            dirty_image[idx] = 1'b0;
        end
        if (cmd == dmwbc_pkg::CMD_WRITE) begin
            line_image[{idx, offs}] = wdata;
            dirty_image[idx]        = 1'b1;
        end else begin
            r.read_data = line_image[{idx, offs}];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        error_count++;
        $display("mismatch on result %0d: %s got %h want %h", results_checked, field, got, want);
    endtask

    task automatic check_result(input logic [31:0] data, input logic [1:0] user);
        access_result_t           want;
        dmwbc_pkg::result_flags_t flags;
        flags = user;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected item", data, '0);
        end else begin
            want = pending_results.pop_front();
            if (data !== want.read_data)
                report_mismatch("read_data", data, want.read_data);
            if (flags.hit !== want.hit)
                report_mismatch("hit", DATA_W'(flags.hit), DATA_W'(want.hit));
            if (flags.wrote_back !== want.wrote_back)
                report_mismatch("wrote_back", DATA_W'(flags.wrote_back),
                                DATA_W'(want.wrote_back));
            if (want.hit) hits_seen++;
            if (want.wrote_back) writebacks_seen++;
        end
        results_checked++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_result(m_tdata, m_tuser);
    end

    // receiver: random stall bursts, plus the long hold when asked
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
                m_tready <= 1'b0;
                repeat (n - 1) @(posedge aclk);
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 8);
                m_tready <= 1'b0;
                repeat (n - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata);
        int gap;
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {wdata, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_access(cmd, addr, wdata));
        items_sent++;
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_address();
        if ($urandom_range(0, 4) == 0)
            return ADDR_W'($urandom);
        return {8'($urandom_range(0, 3)), 5'($urandom), 3'($urandom)};
    endfunction

    function automatic logic pick_command();
        return $urandom_range(0, 1) ? dmwbc_pkg::CMD_WRITE : dmwbc_pkg::CMD_READ;
    endfunction

    task automatic test_directed();
        send_item(dmwbc_pkg::CMD_READ,  16'h0000, 32'h0000_0000);
        send_item(dmwbc_pkg::CMD_READ,  16'h0007, 32'hffff_ffff);
        send_item(dmwbc_pkg::CMD_WRITE, 16'h0003, 32'hffff_ffff);
        send_item(dmwbc_pkg::CMD_READ,  16'h0003, 32'h0000_0000);
        send_item(dmwbc_pkg::CMD_READ,  16'h0103, 32'h0000_0000);
        send_item(dmwbc_pkg::CMD_READ,  16'h0003, 32'h0000_0000);
        send_item(dmwbc_pkg::CMD_WRITE, 16'hffff, 32'hffff_ffff);
        send_item(dmwbc_pkg::CMD_WRITE, 16'hfff8, 32'h0000_0000);
        send_item(dmwbc_pkg::CMD_READ,  16'hffff, 32'h0000_0000);
        send_item(dmwbc_pkg::CMD_WRITE, 16'h00ff, 32'ha5a5_a5a5);
        send_item(dmwbc_pkg::CMD_READ,  16'hffff, 32'h0000_0000);
        send_item(dmwbc_pkg::CMD_READ,  16'h00ff, 32'h0000_0000);
        send_item(dmwbc_pkg::CMD_WRITE, 16'h8000, 32'h5a5a_5a5a);
        send_item(dmwbc_pkg::CMD_WRITE, 16'h7fff, 32'h8000_0001);
        send_item(dmwbc_pkg::CMD_READ,  16'h0000, 32'h0000_0000);
        send_item(dmwbc_pkg::CMD_READ,  16'h8000, 32'h0000_0000);
        send_item(dmwbc_pkg::CMD_READ,  16'h7fff, 32'h0000_0000);
        send_item(dmwbc_pkg::CMD_WRITE, 16'h80ff, 32'h0000_0000);
        send_item(dmwbc_pkg::CMD_READ,  16'h7ff8, 32'h0000_0000);
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_item(pick_command(), pick_address(), $urandom);
    endtask

    // runs of consecutive words that can cross line boundaries
    task automatic test_sequential_runs(input int runs);
        logic [ADDR_W-1:0] addr;
        int                len;
        repeat (runs) begin
            addr = pick_address();
            len  = $urandom_range(8, 16);
            repeat (len) begin
                send_item(pick_command(), addr, $urandom);
                addr = addr + ADDR_W'(1);
            end
        end
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_output_backpressure();
        tx_idle = 1'b0;
        hold_request = LONG_HOLD;
        repeat (24) send_item(pick_command(), pick_address(), $urandom);
        tx_idle = 1'b1;
        wait_for_drain();
    endtask

    task automatic test_full_rate(input int count);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (count)
            send_item(pick_command(),
                      {8'($urandom_range(0, 1)), 5'($urandom_range(0, 3)), 3'($urandom)},
                      $urandom);
    endtask

    initial begin
        int i;
        for (i = 0; i < MEM_DEPTH; i++) mem_image[i] = '0;
        for (i = 0; i < CACHE_LINES * LINE_WORDS; i++) line_image[i] = '0;
        for (i = 0; i < CACHE_LINES; i++) begin
            tag_image[i]   = '0;
            valid_image[i] = 1'b0;
            dirty_image[i] = 1'b0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_traffic(900);
        test_output_backpressure();
        test_sequential_runs(30);
        wait_for_drain();
        test_full_rate(450);

        wait_for_drain();
        $display("sent %0d items, checked %0d results", items_sent, results_checked);
        $display("%0d hits and %0d victim write-backs seen, under idling and a long stall",
                 hits_seen, writebacks_seen);
        if (error_count == 0)
            $display("direct_mapped_writeback_cache test passed");
        else
            $display("direct_mapped_writeback_cache test failed");
        $finish;
    end

endmodule
